@@ sv/cab_pkg.sv @@
// ----------------------------------------------------------------------------
// Countdown alarm bank package
// Shared widths, operation codes, controller states and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cab_pkg;

	localparam int ALARMS_DEF  = 8;
	localparam int MASK_W      = 8;
	localparam int REM_W       = 40;
	localparam int AMOUNT_W    = 24;
	localparam int COUNT_W     = 16;
	localparam int PERIOD_W    = 24;
	localparam int IDX_W       = 4;
	localparam int OP_W        = 2;
	localparam int IN_DATA_W   = 32;
	localparam int OUT_DATA_W  = 56;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1);

	// Register index taken from the word address bit of paddr.
	localparam logic [0:0] REG_BASE_PERIOD = 1'b0;

	typedef enum logic [OP_W-1:0] {
		OP_SET     = 2'd0,
		OP_CLEAR   = 2'd1,
		OP_QUERY   = 2'd2,
		OP_ELAPSED = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MUL    = 5'b00010,
		ST_APPLY  = 5'b00100,
		ST_WALK   = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	typedef struct packed {
		logic load;    // capture the accepted transaction
		logic mul;     // form count times base period
		logic apply;   // write a set or clear to the addressed alarm
		logic walk;    // step the elapsed subtraction by one alarm
		logic finish;  // load the result register
	} cmd_t;

	typedef struct packed {
		logic in_set;      // incoming transaction is a set
		logic in_elapsed;  // incoming transaction is an elapsed event
		logic walk_last;   // walk is on the last alarm
		logic out_free;    // result register can take a new result
	} status_t;

endpackage

@@ sv/cab_ctrl.sv @@
// ----------------------------------------------------------------------------
// Countdown alarm bank controller
// One-hot state machine that sequences each transaction through the datapath.
// ----------------------------------------------------------------------------
module cab_ctrl import cab_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (status.in_elapsed) begin
						state_next = ST_WALK;
					end else if (status.in_set) begin
						state_next = ST_MUL;
					end else begin
						state_next = ST_APPLY;
					end
				end
			end
			ST_MUL: begin
				cmd.mul    = 1'b1;
				state_next = ST_APPLY;
			end
			ST_APPLY: begin
				cmd.apply  = 1'b1;
				state_next = ST_FINISH;
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (status.walk_last) begin
					state_next = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

@@ sv/cab_dp.sv @@
// ----------------------------------------------------------------------------
// Countdown alarm bank datapath
// Alarm registers, set multiplier, shared saturating subtractor and the
// result register.
// ----------------------------------------------------------------------------
module cab_dp import cab_pkg::*; #(
	parameter int ALARMS = ALARMS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output status_t               status,
	input  logic [OP_W-1:0]       in_op,
	input  logic [IDX_W-1:0]      in_idx,
	input  logic [AMOUNT_W-1:0]   in_amount,
	input  logic [PERIOD_W-1:0]   base_period,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [REM_W-1:0]      out_remaining,
	output logic                  out_done,
	output logic [MASK_W-1:0]     out_mask,
	output logic                  out_bad
);

	localparam int SLOT_W = (ALARMS > 1) ? $clog2(ALARMS) : 1;

	logic [REM_W-1:0]    alarm_q [ALARMS];
	logic [MASK_W-1:0]   active_q;
	logic [OP_W-1:0]     op_q;
	logic [IDX_W-1:0]    idx_q;
	logic [AMOUNT_W-1:0] amount_q;
	logic [SLOT_W-1:0]   walk_cnt_q;
	logic [REM_W-1:0]    product_q;
	logic                out_valid_q;

	logic [SLOT_W-1:0]   slot;
	logic                idx_ok;
	logic [SLOT_W-1:0]   rd_addr;
	logic [REM_W-1:0]    rd_val;
	logic [REM_W-1:0]    amount_ext;
	logic [REM_W-1:0]    sub_val;
	logic [MASK_W-1:0]   slot_bit;
	logic [MASK_W-1:0]   walk_bit;

	assign slot       = idx_q[SLOT_W-1:0];
	assign idx_ok     = (idx_q < IDX_W'(ALARMS));
	assign rd_addr    = cmd.walk ? walk_cnt_q : slot;
	assign rd_val     = alarm_q[rd_addr];
	assign amount_ext = REM_W'(amount_q);
	assign sub_val    = (rd_val > amount_ext) ? (rd_val - amount_ext) : '0;
	assign slot_bit   = MASK_W'(1) << slot;
	assign walk_bit   = MASK_W'(1) << walk_cnt_q;

	assign status.in_set     = (in_op == OP_SET);
	assign status.in_elapsed = (in_op == OP_ELAPSED);
	assign status.walk_last  = (walk_cnt_q == SLOT_W'(ALARMS - 1));
	assign status.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= in_op;
			idx_q    <= in_idx;
			amount_q <= in_amount;
		end
		if (cmd.mul) begin
			// Both operands are widened so the full 40-bit product is kept.
			product_q <= {{(REM_W-COUNT_W){1'b0}}, amount_q[COUNT_W-1:0]} *
				{{(REM_W-PERIOD_W){1'b0}}, base_period};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ALARMS; i++) begin
				alarm_q[i] <= '0;
			end
			active_q   <= '0;
			walk_cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				walk_cnt_q <= '0;
			end
			if (cmd.apply && idx_ok) begin
				if (op_q == OP_SET) begin
					alarm_q[slot] <= product_q;
					if (|amount_q[COUNT_W-1:0]) begin
						active_q <= active_q | slot_bit;
					end else begin
						active_q <= active_q & ~slot_bit;
					end
				end else if (op_q == OP_CLEAR) begin
					alarm_q[slot] <= '0;
					active_q      <= active_q & ~slot_bit;
				end
			end
			if (cmd.walk) begin
				walk_cnt_q <= walk_cnt_q + SLOT_W'(1);
				if (rd_val != '0) begin
					alarm_q[walk_cnt_q] <= sub_val;
					if (sub_val == '0) begin
						active_q <= active_q & ~walk_bit;
					end
				end
			end
		end
	end

	// Result register: the next transaction may be worked on while this waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_remaining <= idx_ok ? rd_val : '0;
			out_done      <= !idx_ok || (rd_val == '0);
			out_mask      <= active_q;
			out_bad       <= !idx_ok && (op_q != OP_ELAPSED);
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ sv/countdown_alarm_bank_unit.sv @@
// ----------------------------------------------------------------------------
// Countdown alarm bank unit
// A set passes through the multiply, apply and finish states, a clear or query
// through apply and finish, an elapsed event through the one-alarm-per-cycle walk
// in the shared subtractor and then finish, which waits for a free result register.
// One transaction is in work at a time, so the next is accepted only after finish;
// a waiting result does not hold off the next accept.
// Reset (arst_n low, asynchronous) zeroes all alarms and active bits, base_period 1.
// ----------------------------------------------------------------------------
module countdown_alarm_bank_unit import cab_pkg::*; #(
	parameter int ALARMS = ALARMS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream.
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_DATA_W-1:0]   s_axis_tdata,  // alarm_index[3:0], amount[27:4], zero
	input  logic [OP_W-1:0]        s_axis_tuser,  // op[1:0]
	// Result stream.
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_DATA_W-1:0]  m_axis_tdata,  // remaining[39:0], done_res[40],
	                                              // active_mask[48:41], bad_index[49], zero
	// Configuration port.
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready
);

	cmd_t                 cmd;
	status_t              status;
	logic [PERIOD_W-1:0]  base_period_q;
	logic [REM_W-1:0]     remaining;
	logic                 done_res;
	logic [MASK_W-1:0]    active_mask;
	logic                 bad_index;
	logic                 reg_hit;

	// The only register sits at word 0; any other word reads back zero and
	// ignores writes.
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2:2] == REG_BASE_PERIOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_period_q <= PERIOD_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			base_period_q <= pwdata[PERIOD_W-1:0];
		end
	end

	assign prdata = reg_hit ? APB_DATA_W'(base_period_q) : '0;

	// The controller walks each transaction through multiply, apply or the
	// per-alarm elapsed walk, then hands the result to the output register.
	cab_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	cab_dp #(
		.ALARMS (ALARMS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.in_op         (s_axis_tuser),
		.in_idx        (s_axis_tdata[IDX_W-1:0]),
		.in_amount     (s_axis_tdata[IDX_W+AMOUNT_W-1:IDX_W]),
		.base_period   (base_period_q),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_remaining (remaining),
		.out_done      (done_res),
		.out_mask      (active_mask),
		.out_bad       (bad_index)
	);

	// Result fields packed from the lowest bit up, padded to whole bytes.
	assign m_axis_tdata = {6'b0, bad_index, active_mask, done_res, remaining};

endmodule

@@ dv/countdown_alarm_bank_checker.sv @@
// ----------------------------------------------------------------------------
// Countdown alarm bank checker
// Watches the command, result and configuration channels, predicts each
// result from its own model of the alarm bank, and compares field by field.
// ----------------------------------------------------------------------------
module countdown_alarm_bank_checker import cab_pkg::*; #(
	parameter int ALARMS = ALARMS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // alarm_index[3:0], amount[27:4], zero
	input  logic [OP_W-1:0]       s_axis_tuser,   // op[1:0]
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // remaining[39:0], done_res[40],
	                                              // active_mask[48:41], bad_index[49], zero
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic                  pready,
	output int unsigned           mismatches,
	output int unsigned           outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [REM_W-1:0]  remaining;
		logic              done_res;
		logic [MASK_W-1:0] active_mask;
		logic              bad_index;
	} alarm_report_t;

	logic [REM_W-1:0]    alarm_left [ALARMS_DEF];
	logic [MASK_W-1:0]   armed;
	logic [PERIOD_W-1:0] base_period;
	alarm_report_t       reports_due [$];

	function automatic alarm_report_t step_alarms(op_t op, logic [IDX_W-1:0] idx,
			logic [AMOUNT_W-1:0] amt);
		alarm_report_t    rpt;
		logic             in_range;
		logic [2:0]       slot;
		logic [REM_W-1:0] left;
		in_range = idx < ALARMS;
		slot = idx[2:0];
		rpt.bad_index = 1'b0;
		if (op == OP_ELAPSED) begin
			// Zero alarms are skipped, so a zero-period alarm keeps its active bit.
			for (int i = 0; i < ALARMS; i++) begin
				if (alarm_left[i] != '0) begin
					alarm_left[i] = (alarm_left[i] > REM_W'(amt)) ?
						alarm_left[i] - REM_W'(amt) : '0;
					if (alarm_left[i] == '0)
						armed[i] = 1'b0;
				end
			end
		end else if (!in_range) begin
			rpt.bad_index = 1'b1;
		end else if (op == OP_SET) begin
			alarm_left[slot] = REM_W'(amt[COUNT_W-1:0]) * REM_W'(base_period);
			armed[slot] = amt[COUNT_W-1:0] != '0;
		end else if (op == OP_CLEAR) begin
			alarm_left[slot] = '0;
			armed[slot] = 1'b0;
		end
		left = in_range ? alarm_left[slot] : '0;
		rpt.remaining = left;
		rpt.done_res = left == '0;
		rpt.active_mask = armed;
		return rpt;
	endfunction

	task automatic flag_field(string field, logic [REM_W-1:0] want, logic [REM_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		alarm_report_t want;
		alarm_report_t got;
		if (!arst_n) begin
			for (int i = 0; i < ALARMS_DEF; i++)
				alarm_left[i] = '0;
			armed = '0;
			base_period = PERIOD_RESET;
			reports_due.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_BASE_PERIOD)
				base_period = pwdata[PERIOD_W-1:0];

			if (m_axis_tvalid && m_axis_tready) begin
				got.remaining = m_axis_tdata[REM_W-1:0];
				got.done_res = m_axis_tdata[REM_W];
				got.active_mask = m_axis_tdata[REM_W+1 +: MASK_W];
				got.bad_index = m_axis_tdata[REM_W+1+MASK_W];
				if (reports_due.size() == 0) begin
					mismatches++;
					$display("%0t: result 0x%0h arrived with none outstanding",
						$time, m_axis_tdata);
				end else begin
					want = reports_due.pop_front();
					flag_field("remaining", want.remaining, got.remaining);
					flag_field("done_res", REM_W'(want.done_res), REM_W'(got.done_res));
					flag_field("active_mask", REM_W'(want.active_mask),
						REM_W'(got.active_mask));
					flag_field("bad_index", REM_W'(want.bad_index), REM_W'(got.bad_index));
				end
			end

			if (s_axis_tvalid && s_axis_tready)
				reports_due.push_back(step_alarms(op_t'(s_axis_tuser),
					s_axis_tdata[IDX_W-1:0], s_axis_tdata[IDX_W +: AMOUNT_W]));

			outstanding = reports_due.size();
		end
	end

endmodule

@@ dv/countdown_alarm_bank_unit_test.sv @@
// ----------------------------------------------------------------------------
// Countdown alarm bank unit testbench
// Drives directed and random alarm commands through the input stream under
// several base periods, with random stalls on both streams; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module countdown_alarm_bank_unit_test;
	import cab_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 225;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // alarm_index[3:0], amount[27:4], zero
	logic [OP_W-1:0]       s_axis_tuser = '0;   // op[1:0]
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b1;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // remaining[39:0], done_res[40],
	                                            // active_mask[48:41], bad_index[49], zero
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int unsigned           mismatches;
	int unsigned           outstanding;

	// When calm is set, neither the command sender nor the result receiver stalls.
	logic                  calm = 1'b0;
	// The sender's copy of the base period, used to scale elapsed amounts so that
	// alarms actually run down to zero.
	logic [PERIOD_W-1:0]   period_now = PERIOD_RESET;

	always #5 clk = ~clk;

	countdown_alarm_bank_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	countdown_alarm_bank_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	// The result receiver drops tready at random, one time in ten, except while calm.
	always @(negedge clk)
		m_axis_tready <= calm || ($urandom_range(99) >= 10);

	// Sends one command transaction. It is entered and left at a falling edge.
	// After acceptance tvalid stays high, so that a following command without
	// a gap goes out back to back; the next call or the caller lowers it.
	task automatic push_command(op_t op, logic [IDX_W-1:0] idx, logic [AMOUNT_W-1:0] amt);
		int unsigned gap;
		gap = (!calm && $urandom_range(99) < 10) ? $urandom_range(6, 1) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(IN_DATA_W-IDX_W-AMOUNT_W){1'b0}}, amt, idx};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Writes base_period over the configuration port. The bank must be idle, so
	// the sender stops and every outstanding result is drained first. Every
	// command yields a result, so an empty checker queue means nothing is in work.
	task automatic set_base_period(logic [APB_DATA_W-1:0] word);
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		period_now = word[PERIOD_W-1:0];
	endtask

	initial begin
		op_t                 op;
		logic [IDX_W-1:0]    idx;
		logic [AMOUNT_W-1:0] amt;
		logic [APB_DATA_W-1:0] word;
		int unsigned         pick;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at unit base period. The upper pwdata bits are not part
		// of the register and must be dropped.
		set_base_period(32'hA500_0001);
		push_command(OP_SET, 0, 24'hFFFFFF);     // largest count, upper amount bits ignored
		push_command(OP_SET, 7, 24'h000001);
		push_command(OP_SET, 3, 24'hAB0000);     // zero count leaves the alarm idle
		push_command(OP_QUERY, 0, 24'h000000);
		push_command(OP_QUERY, 7, 24'h000000);
		push_command(OP_QUERY, 8, 24'h000000);   // out-of-range index, used below on every operation
		push_command(OP_SET, 15, 24'h000010);
		push_command(OP_CLEAR, 9, 24'h000000);
		push_command(OP_QUERY, 15, 24'hFFFFFF);
		push_command(OP_CLEAR, 7, 24'h000000);
		push_command(OP_ELAPSED, 0, 24'h000000); // no time passed, nothing changes
		push_command(OP_ELAPSED, 12, 24'h000005); // out-of-range index still counts down
		push_command(OP_ELAPSED, 0, 24'hFFFFFF); // saturates alarm 0 at zero
		push_command(OP_QUERY, 0, 24'h000000);

		// A zero period arms an alarm that holds zero; elapsed never drops it.
		set_base_period(32'h0000_0000);
		push_command(OP_SET, 2, 24'h000005);
		push_command(OP_ELAPSED, 2, 24'h000003);
		push_command(OP_QUERY, 2, 24'h000000);
		push_command(OP_CLEAR, 2, 24'h000000);

		// Largest period with the largest count fills the whole 40-bit remaining time.
		set_base_period(32'h00FF_FFFF);
		push_command(OP_SET, 5, 24'h00FFFF);
		push_command(OP_ELAPSED, 5, 24'hFFFFFF);
		push_command(OP_QUERY, 5, 24'h000000);
		push_command(OP_SET, 6, 24'h000001);
		push_command(OP_ELAPSED, 6, 24'hFFFFFF); // exactly one period expires alarm 6

		// Random part: one base period per phase, extremes included. Phase three
		// runs with no stalls on either side.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: word = 32'h0000_0001;
				1: word = 32'h00FF_FFFF;
				2: word = 32'h0000_0000;
				3: word = APB_DATA_W'($urandom_range(255, 2));
				4: word = $urandom;
				5: word = 32'h0000_0003;
				6: word = APB_DATA_W'($urandom_range(65535, 256));
				default: word = 32'h00FF_FFFE;
			endcase
			set_base_period(word);
			calm = phase == 3;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(99);
				op = pick < 30 ? OP_SET : pick < 40 ? OP_CLEAR : pick < 65 ? OP_QUERY :
					OP_ELAPSED;
				idx = ($urandom_range(99) < 85) ? IDX_W'($urandom_range(ALARMS_DEF - 1)) :
					IDX_W'($urandom_range(15, ALARMS_DEF));
				case (op)
					OP_SET: begin
						// Half the sets use small counts so that alarms expire often.
						if ($urandom_range(1) != 0)
							amt = {8'($urandom), 16'($urandom_range(4))};
						else
							amt = AMOUNT_W'($urandom);
					end
					OP_ELAPSED: begin
						case ($urandom_range(4))
							0: amt = '0;
							1: amt = AMOUNT_W'($urandom_range(16, 1));
							2: amt = AMOUNT_W'(period_now * $urandom_range(3, 1));
							3: amt = AMOUNT_W'($urandom);
							default: amt = '1;
						endcase
					end
					default: amt = AMOUNT_W'($urandom);
				endcase
				push_command(op, idx, amt);
			end
		end
		calm = 1'b0;

		// Drain, then allow a little more than the longest command latency so
		// that any stray result still shows up at the checker.
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("countdown_alarm_bank_unit_test: PASS");
		end else begin
			$display("countdown_alarm_bank_unit_test: FAIL");
		end
		$finish;
	end

	// A run that has not finished by this time limit is reported as a failure.
	initial begin
		#5ms;
		$display("countdown_alarm_bank_unit_test: FAIL");
		$finish;
	end

endmodule

@@ countdown_alarm_bank_unit.f @@
sv/cab_pkg.sv
sv/cab_ctrl.sv
sv/cab_dp.sv
sv/countdown_alarm_bank_unit.sv
dv/countdown_alarm_bank_checker.sv
dv/countdown_alarm_bank_unit_test.sv
